@@ design/htfd_pkg.sv @@
`timescale 1ns / 1ps

package htfd_pkg;

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 16;
   localparam int READING_W = 15;
   localparam int STATUS_W  = 2;
   localparam int REQ_DATA_W = 24;   // raw_high, raw_low, check_byte
   localparam int RSP_DATA_W = 24;   // reading, status, zero fill

   // Measurement kinds
   localparam logic KIND_TEMP = 1'b0;
   localparam logic KIND_HUM  = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CRC_BAD  = 2'd1,
      STATUS_KIND_BAD = 2'd2
   } status_type;

   // Check results handed from the CRC/flag checker to the converter
   typedef struct packed {
      logic crc_bad;
      logic kind_bad;
   } check_type;

   // Temperature: (-4685*2^14 + 4393*w + 2^13) / 2^14, truncated toward zero
   localparam int TEMP_SHIFT = 14;
   localparam int TEMP_SUM_W = 30;
   localparam int TEMP_PROD_W = 29;
   localparam logic [12:0] TEMP_GAIN = 13'd4393;
   localparam logic signed [TEMP_SUM_W-1:0] TEMP_BIAS =
      TEMP_SUM_W'(-4685 * 16384 + 8192);
   localparam logic signed [TEMP_SUM_W-1:0] TEMP_ROUND =
      TEMP_SUM_W'((1 << TEMP_SHIFT) - 1);

   // Humidity: floor((125*w + 2^14) / 2^15) - 12
   localparam int HUM_SHIFT = 15;
   localparam int HUM_PROD_W = 23;
   localparam logic [6:0] HUM_GAIN = 7'd125;
   localparam logic [HUM_PROD_W-1:0] HUM_BIAS = HUM_PROD_W'(16384);
   localparam logic signed [READING_W-1:0] HUM_OFFSET = READING_W'(12);

   // CRC-8 (x^8+x^5+x^4+1, init 0, MSB first) is linear in the data word:
   // entry i is the CRC of a word with only bit i set.
   localparam logic [BYTE_W-1:0] CRC_COL [WORD_W] = '{
      8'h31, 8'h62, 8'hC4, 8'hB9, 8'h43, 8'h86, 8'h3D, 8'h7A,
      8'hF4, 8'hD9, 8'h83, 8'h37, 8'h6E, 8'hDC, 8'h89, 8'h23
   };

   function automatic logic [BYTE_W-1:0] crc8_word(input logic [WORD_W-1:0] word);
      logic [BYTE_W-1:0] crc;
      crc = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (word[i]) begin
            crc = crc ^ CRC_COL[i];
         end
      end
      return crc;
   endfunction

endpackage

@@ design/htfd_check.sv @@
`timescale 1ns / 1ps

module htfd_check (
   input  logic                        kind,
   input  logic [htfd_pkg::BYTE_W-1:0] raw_high,
   input  logic [htfd_pkg::BYTE_W-1:0] raw_low,
   input  logic [htfd_pkg::BYTE_W-1:0] check_byte,
   output htfd_pkg::check_type         check
);
   import htfd_pkg::*;

   logic [BYTE_W-1:0] crc;

   // CRC over high byte then low byte
   assign crc = crc8_word({raw_high, raw_low});

   // Bit 1 of the low byte must agree with the measurement kind
   assign check.crc_bad  = (crc != check_byte);
   assign check.kind_bad = (raw_low[1] != kind);

endmodule

@@ design/htfd_convert.sv @@
`timescale 1ns / 1ps

module htfd_convert (
   input  logic                                  kind,
   input  logic [htfd_pkg::BYTE_W-1:0]           raw_high,
   input  logic [htfd_pkg::BYTE_W-1:0]           raw_low,
   input  htfd_pkg::check_type                   check,
   output logic signed [htfd_pkg::READING_W-1:0] reading,
   output htfd_pkg::status_type                  status
);
   import htfd_pkg::*;

   logic [WORD_W-1:0]                word;
   logic [TEMP_PROD_W-1:0]           temp_prod;
   logic signed [TEMP_SUM_W-1:0]     temp_sum;
   logic signed [TEMP_SUM_W-1:0]     temp_adj;
   logic signed [READING_W-1:0]      temp_val;
   logic [HUM_PROD_W-1:0]            hum_sum;
   logic signed [READING_W-1:0]      hum_val;

   // Raw word with the two status bits cleared
   assign word = {raw_high, raw_low[BYTE_W-1:2], 2'b00};

   // Temperature: signed sum, bias toward zero before the arithmetic shift
   assign temp_prod = TEMP_PROD_W'(word) * TEMP_PROD_W'(TEMP_GAIN);
   assign temp_sum  = $signed({1'b0, temp_prod}) + TEMP_BIAS;
   assign temp_adj  = temp_sum[TEMP_SUM_W-1] ? (temp_sum + TEMP_ROUND) : temp_sum;
   assign temp_val  = temp_adj[TEMP_SHIFT +: READING_W];

   // Humidity: unsigned sum, plain floor shift
   assign hum_sum = HUM_PROD_W'(word) * HUM_PROD_W'(HUM_GAIN) + HUM_BIAS;
   assign hum_val = $signed(READING_W'(hum_sum[HUM_PROD_W-1:HUM_SHIFT])) - HUM_OFFSET;

   // CRC error wins over the kind flag error; errors read as zero
   always_comb begin
      priority if (check.crc_bad) begin
         status  = STATUS_CRC_BAD;
         reading = '0;
      end else if (check.kind_bad) begin
         status  = STATUS_KIND_BAD;
         reading = '0;
      end else begin
         status  = STATUS_OK;
         reading = (kind == KIND_HUM) ? hum_val : temp_val;
      end
   end

endmodule

@@ design/humidity_temp_frame_decode.sv @@
`timescale 1ns / 1ps
// Path: a req item is held in the input register, then in the result register,
//    before it shows as a valid rsp item.
// Throughput: one item per cycle while rsp is taken; when it is not, the result
//    register holds and the input register still fills if empty, then holds too.
// Reset: synchronous, active high; clears both stage valid flags, no data reset.

module humidity_temp_frame_decode (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: raw_high [7:0], raw_low [15:8], check_byte [23:16]
   input  logic [htfd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: req_type [0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: reading [14:0], status [16:15], zero [23:17]
   output logic [htfd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import htfd_pkg::*;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_kind_ff;
   logic [BYTE_W-1:0]             s1_high_ff, s1_low_ff, s1_check_ff;
   logic                          out_valid_ff, out_valid_in;
   logic signed [READING_W-1:0]   out_reading_ff;
   status_type                    out_status_ff;

   logic                          s1_ready;
   logic                          out_ready;
   logic                          s1_load;
   logic                          out_load;
   check_type                     check;
   logic signed [READING_W-1:0]   reading;
   status_type                    status;

   // Stage handshakes
   assign out_ready = !out_valid_ff || rsp_tready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign s1_load   = req_tvalid && s1_ready;
   assign out_load  = s1_valid_ff && out_ready;

   assign s1_valid_in  = s1_load || (s1_valid_ff && !out_ready);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_kind_ff  <= req_tuser;
         s1_high_ff  <= req_tdata[BYTE_W-1:0];
         s1_low_ff   <= req_tdata[2*BYTE_W-1:BYTE_W];
         s1_check_ff <= req_tdata[3*BYTE_W-1:2*BYTE_W];
      end
   end

   htfd_check u_check (
      .kind       (s1_kind_ff),
      .raw_high   (s1_high_ff),
      .raw_low    (s1_low_ff),
      .check_byte (s1_check_ff),
      .check      (check)
   );

   htfd_convert u_convert (
      .kind     (s1_kind_ff),
      .raw_high (s1_high_ff),
      .raw_low  (s1_low_ff),
      .check    (check),
      .reading  (reading),
      .status   (status)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_reading_ff <= reading;
         out_status_ff  <= status;
      end
   end

   assign req_tready = s1_ready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - READING_W - STATUS_W)'(0), out_status_ff,
                        out_reading_ff};

endmodule

@@ design/htfd_checker.sv @@
`timescale 1ns / 1ps

module htfd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic [htfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);
   import htfd_pkg::*;

   logic [STATUS_W-1:0]  rsp_status;
   logic [READING_W-1:0] rsp_reading;

   assign rsp_status  = rsp_tdata[READING_W +: STATUS_W];
   assign rsp_reading = rsp_tdata[READING_W-1:0];

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed");

   // Errors carry a zero reading, and the unused status code never shows
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != STATUS_OK) |-> rsp_reading == '0)
      else $error("error item with nonzero reading");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_CRC_BAD)
                     || (rsp_status == STATUS_KIND_BAD))
      else $error("bad status code");

   // With the result register empty the input side must be open
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled while rsp empty");

endmodule

bind humidity_temp_frame_decode htfd_checker u_htfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
